// ===== src/obs_pkg.sv =====
// Shared types and constants for the overlap box suppression block.
// Used by obs_cell, obs_scale and the overlap_box_suppression top level.
// No dependencies.
`default_nettype none

package obs_pkg;

	localparam int WORD_W       = 24;
	localparam int SCALE_W      = 16;
	localparam int ROW_LEN      = 20;
	localparam int POS_W        = 5;
	localparam int DEF_MAX_ROWS = 128;

	// Word positions inside one row.
	localparam int CORNER_CNT = 8;
	localparam int LOGIT_POS  = 8;
	localparam int COLOR_POS  = 9;
	localparam int COLOR_LAST = 12;
	localparam int TAG_POS    = 13;
	localparam int TAG_LAST   = 19;

	localparam int CIDX_W    = 3;
	localparam int COLOR_W   = 2;
	localparam int TAG_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam int FRAC_SHIFT = 12;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4096;

	// Result packing, lowest bits first.
	localparam int LOGIT_LSB = CORNER_CNT * WORD_W;
	localparam int COLOR_LSB = LOGIT_LSB + WORD_W;
	localparam int TAG_LSB   = COLOR_LSB + COLOR_W;
	localparam int OUT_BITS  = TAG_LSB + TAG_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t lo_x;
		word_t lo_y;
		word_t hi_x;
		word_t hi_y;
	} rect_t;

	// Candidate box travelling down the cell chain.
	typedef struct packed {
		logic  active;
		logic  hit;
		rect_t rect;
	} link_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X    = 2'd0,
		REG_SCALE_Y    = 2'd1,
		REG_KEEP_LOGIT = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/obs_cell.sv =====
// One cell of the kept-box chain: holds one kept rectangle and tests the
// passing candidate against it. Depends on obs_pkg.
`default_nettype none

module obs_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  obs_pkg::link_t link_in,
	output obs_pkg::link_t link_out
);
	import obs_pkg::*;

	logic  valid_q;
	rect_t box_q;
	logic  act_q;
	logic  hit_q;
	rect_t rect_q;
	logic  meet;
	logic  store;

	// Strictly positive overlap on both axes: every high edge lies above every low edge.
	always_comb begin
		meet = ($signed(link_in.rect.hi_x) > $signed(box_q.lo_x)) &&
		       ($signed(box_q.hi_x) > $signed(link_in.rect.lo_x)) &&
		       ($signed(link_in.rect.hi_x) > $signed(link_in.rect.lo_x)) &&
		       ($signed(box_q.hi_x) > $signed(box_q.lo_x)) &&
		       ($signed(link_in.rect.hi_y) > $signed(box_q.lo_y)) &&
		       ($signed(box_q.hi_y) > $signed(link_in.rect.lo_y)) &&
		       ($signed(link_in.rect.hi_y) > $signed(link_in.rect.lo_y)) &&
		       ($signed(box_q.hi_y) > $signed(box_q.lo_y));
	end

	// Cells fill in order, so the first empty cell a clean candidate meets is its slot.
	assign store = link_in.active && !valid_q && !link_in.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= 1'b0;
			end else if (store) begin
				valid_q <= 1'b1;
			end
			act_q <= link_in.active && valid_q;
			hit_q <= link_in.hit || (valid_q && meet);
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			box_q <= link_in.rect;
		end
		rect_q <= link_in.rect;
	end

	assign link_out = '{active: act_q, hit: hit_q, rect: rect_q};

endmodule

`default_nettype wire

// ===== src/obs_scale.sv =====
// Two-stage corner scaler: multiply by a Q4.12 ratio, round half up,
// shift and saturate to 24 bits. Depends on obs_pkg.
`default_nettype none

module obs_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         issue,
	input  obs_pkg::word_t               coord,
	input  logic [obs_pkg::SCALE_W-1:0]  scale,
	input  logic [obs_pkg::CIDX_W-1:0]   idx_in,
	output logic                         res_valid,
	output logic [obs_pkg::CIDX_W-1:0]   res_idx,
	output obs_pkg::word_t               res
);
	import obs_pkg::*;

	localparam int PROD_W = WORD_W + SCALE_W + 1;
	localparam int Q_W    = PROD_W - FRAC_SHIFT;
	localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(1) << (FRAC_SHIFT - 1);
	localparam logic signed [Q_W-1:0]    Q_MAX  = Q_W'((2 ** (WORD_W - 1)) - 1);
	localparam logic signed [Q_W-1:0]    Q_MIN  = Q_W'(-(2 ** (WORD_W - 1)));
	localparam logic signed [WORD_W-1:0] W_MAX  = WORD_W'((2 ** (WORD_W - 1)) - 1);
	localparam logic signed [WORD_W-1:0] W_MIN  = WORD_W'(-(2 ** (WORD_W - 1)));

	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1;
	logic [CIDX_W-1:0]        idx_s1;
	logic signed [PROD_W-1:0] rnd;
	logic signed [Q_W-1:0]    q;
	word_t                    sat;
	word_t                    res_s2;
	logic                     valid_s2;
	logic [CIDX_W-1:0]        idx_s2;

	always_comb begin
		rnd = prod_s1 + ROUND;
		q   = rnd[PROD_W-1:FRAC_SHIFT];
		if (q > Q_MAX) begin
			sat = W_MAX;
		end else if (q < Q_MIN) begin
			sat = W_MIN;
		end else begin
			sat = q[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(coord) * $signed({1'b0, scale});
		idx_s1  <= idx_in;
		res_s2  <= sat;
		idx_s2  <= idx_s1;
	end

	assign res_valid = valid_s2;
	assign res_idx   = idx_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

// ===== src/overlap_box_suppression.sv =====
// Top level of the overlap box suppression block: row gathering, the
// kept-box cell chain, control and result register.
// Depends on obs_pkg, obs_cell and obs_scale.
//
// Input stream (s_*): one signed Q15.8 word per request, 20 words per row,
// rows sorted by confidence; s_tuser marks the first word of a new frame.
// Output stream (m_*): one request per kept row with scaled corners, raw
// logit and color and tag indices. Config channel (cfg_*) is always ready.
// Words are taken at one per cycle inside a row. After the 20th word of a row
// at or above the threshold the input is held off while the candidate walks
// past the K boxes kept so far, one cell per cycle. A kept row then has its 8
// corner words scaled on the single shared multiplier before the input opens
// again. While a previous result still waits, words keep flowing; the next kept
// row's scaling, and with it the input, waits for the output register to
// empty. Reset empties the chain, stops the frame until a word with s_tuser set
// arrives, and loads scales of 1.0 and a threshold of 0.
`default_nettype none

module overlap_box_suppression #(
	parameter int MAX_ROWS = obs_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [obs_pkg::WORD_W-1:0]     s_tdata,   // [23:0] word
	input  logic                           s_tuser,   // [0] frame_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [23:0] corner0_x, [47:24] corner0_y, [71:48] corner1_x, [95:72] corner1_y,
	// [119:96] corner2_x, [143:120] corner2_y, [167:144] corner3_x,
	// [191:168] corner3_y, [215:192] confidence_logit, [217:216] color_index,
	// [220:218] tag_index, [223:221] zero
	output logic [obs_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [obs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [obs_pkg::WORD_W-1:0]     cfg_data
);
	import obs_pkg::*;

	localparam int CNT_W = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_COLLECT = 3'b001,
		ST_CHECK   = 3'b010,
		ST_SCALE   = 3'b100
	} state_t;

	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   row_count_q;
	logic [CNT_W-1:0]   kept_count_q;
	logic [CNT_W-1:0]   walk_q;
	logic               stopped_q;
	logic [SCALE_W-1:0] scale_x_q;
	logic [SCALE_W-1:0] scale_y_q;
	word_t              keep_logit_q;

	word_t              corner_q [CORNER_CNT];
	rect_t              rect_q;
	word_t              logit_q;
	word_t              color_best_q;
	logic [COLOR_W-1:0] color_idx_q;
	word_t              tag_best_q;
	logic [TAG_W-1:0]   tag_idx_q;

	logic               link0_act_q;
	rect_t              link0_rect_q;
	link_t              link [MAX_ROWS+1];
	logic [MAX_ROWS:0]  link_hit;

	logic [CIDX_W-1:0]  sc_idx_q;
	logic               out_valid_q;
	word_t              out_corner_q [CORNER_CNT];
	word_t              out_logit_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [TAG_W-1:0]   out_tag_q;

	logic               in_acc;
	logic               take;
	logic               frame_clear;
	logic [POS_W-1:0]   cur_pos;
	logic [CNT_W-1:0]   rc_base;
	logic               row_end;
	logic               below;
	logic               decide;
	logic               hit_at_tail;
	logic               issue;
	word_t              word;
	word_t              sc_coord;
	logic [SCALE_W-1:0] sc_scale;
	logic               res_valid;
	logic [CIDX_W-1:0]  res_idx;
	word_t              res;

	assign s_tready  = (state_q == ST_COLLECT);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;

	assign word        = $signed(s_tdata);
	assign in_acc      = s_tvalid && s_tready;
	assign frame_clear = in_acc && s_tuser;
	assign take        = in_acc && (s_tuser || !stopped_q);
	assign cur_pos     = s_tuser ? '0 : pos_q;
	assign rc_base     = s_tuser ? '0 : row_count_q;
	assign row_end     = take && (cur_pos == POS_W'(ROW_LEN - 1));
	assign below       = $signed(logit_q) < $signed(keep_logit_q);
	assign decide      = (state_q == ST_CHECK) && (walk_q == kept_count_q);
	assign hit_at_tail = link_hit[kept_count_q];
	assign issue       = (state_q == ST_SCALE) && ((sc_idx_q != '0) || !out_valid_q);
	assign sc_coord    = corner_q[sc_idx_q];
	assign sc_scale    = sc_idx_q[0] ? scale_y_q : scale_x_q;

	// Cell chain; link[i] feeds cell i, link[0] is the injection register.
	assign link[0] = '{active: link0_act_q, hit: 1'b0, rect: link0_rect_q};

	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		obs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (frame_clear),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	for (genvar i = 0; i <= MAX_ROWS; i++) begin : g_hit
		assign link_hit[i] = link[i].hit;
	end

	obs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.coord     (sc_coord),
		.scale     (sc_scale),
		.idx_in    (sc_idx_q),
		.res_valid (res_valid),
		.res_idx   (res_idx),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_COLLECT;
			pos_q        <= '0;
			row_count_q  <= '0;
			kept_count_q <= '0;
			walk_q       <= '0;
			stopped_q    <= 1'b1;
			link0_act_q  <= 1'b0;
			sc_idx_q     <= '0;
			out_valid_q  <= 1'b0;
			scale_x_q    <= SCALE_RST;
			scale_y_q    <= SCALE_RST;
			keep_logit_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SCALE_X:    scale_x_q    <= cfg_data[SCALE_W-1:0];
					REG_SCALE_Y:    scale_y_q    <= cfg_data[SCALE_W-1:0];
					REG_KEEP_LOGIT: keep_logit_q <= $signed(cfg_data);
					default: ;
				endcase
			end

			// A completed row at or above the threshold enters the chain for one cycle.
			link0_act_q <= (state_q == ST_COLLECT) && row_end && !below;

			case (state_q)
				ST_COLLECT: begin
					if (take) begin
						if (s_tuser) begin
							stopped_q    <= 1'b0;
							kept_count_q <= '0;
						end
						if (row_end) begin
							pos_q       <= '0;
							row_count_q <= rc_base + 1'b1;
							if (below) begin
								stopped_q <= 1'b1;
							end else begin
								if (rc_base >= CNT_W'(MAX_ROWS - 1)) begin
									stopped_q <= 1'b1;
								end
								walk_q      <= '0;
								state_q     <= ST_CHECK;
							end
						end else begin
							pos_q       <= cur_pos + 1'b1;
							row_count_q <= rc_base;
						end
					end
				end
				ST_CHECK: begin
					if (decide) begin
						if (hit_at_tail) begin
							state_q <= ST_COLLECT;
						end else begin
							kept_count_q <= kept_count_q + 1'b1;
							sc_idx_q     <= '0;
							state_q      <= ST_SCALE;
						end
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_SCALE: begin
					if (issue) begin
						sc_idx_q <= sc_idx_q + 1'b1;
						if (sc_idx_q == CIDX_W'(CORNER_CNT - 1)) begin
							state_q <= ST_COLLECT;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase

			if (res_valid && (res_idx == CIDX_W'(CORNER_CNT - 1))) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Row gathering: corners, running bounding box, logit and running argmax.
	always_ff @(posedge clk) begin
		if (take) begin
			if (cur_pos < POS_W'(CORNER_CNT)) begin
				corner_q[cur_pos[CIDX_W-1:0]] <= word;
				if (!cur_pos[0]) begin
					if (cur_pos < POS_W'(2)) begin
						rect_q.lo_x <= word;
						rect_q.hi_x <= word;
					end else begin
						if (word < $signed(rect_q.lo_x)) rect_q.lo_x <= word;
						if (word > $signed(rect_q.hi_x)) rect_q.hi_x <= word;
					end
				end else begin
					if (cur_pos < POS_W'(2)) begin
						rect_q.lo_y <= word;
						rect_q.hi_y <= word;
					end else begin
						if (word < $signed(rect_q.lo_y)) rect_q.lo_y <= word;
						if (word > $signed(rect_q.hi_y)) rect_q.hi_y <= word;
					end
				end
			end
			if (cur_pos == POS_W'(LOGIT_POS)) begin
				logit_q <= word;
			end
			if (cur_pos == POS_W'(COLOR_POS)) begin
				color_best_q <= word;
				color_idx_q  <= '0;
			end else if ((cur_pos > POS_W'(COLOR_POS)) && (cur_pos <= POS_W'(COLOR_LAST)) &&
			             (word > $signed(color_best_q))) begin
				color_best_q <= word;
				color_idx_q  <= COLOR_W'(cur_pos - POS_W'(COLOR_POS));
			end
			if (cur_pos == POS_W'(TAG_POS)) begin
				tag_best_q <= word;
				tag_idx_q  <= '0;
			end else if ((cur_pos > POS_W'(TAG_POS)) && (cur_pos <= POS_W'(TAG_LAST)) &&
			             (word > $signed(tag_best_q))) begin
				tag_best_q <= word;
				tag_idx_q  <= TAG_W'(cur_pos - POS_W'(TAG_POS));
			end
		end

		if (row_end) begin
			link0_rect_q <= rect_q;
		end

		if (issue && (sc_idx_q == '0)) begin
			out_logit_q <= logit_q;
			out_color_q <= color_idx_q;
			out_tag_q   <= tag_idx_q;
		end
		if (res_valid) begin
			out_corner_q[res_idx] <= res;
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int k = 0; k < CORNER_CNT; k++) begin
			m_tdata[k*WORD_W +: WORD_W] = out_corner_q[k];
		end
		m_tdata[LOGIT_LSB +: WORD_W]  = out_logit_q;
		m_tdata[COLOR_LSB +: COLOR_W] = out_color_q;
		m_tdata[TAG_LSB +: TAG_W]     = out_tag_q;
	end

`ifndef SYNTHESIS
	a_kept_le_rows: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= row_count_q)
		else $error("more boxes kept than rows completed");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (walk_q <= kept_count_q))
		else $error("candidate walked past the last kept box");

	a_cand_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> link[walk_q].active)
		else $error("no active candidate at the tracked chain position");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid_q)
		else $error("scaled corner written while a result is pending");
`endif

endmodule

`default_nettype wire
